// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masks the check
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/flw_pkg.sv =====
// shared types, constants and helpers of the line walker
package flw_pkg;

    localparam int COORD_BITS = 7;
    localparam int ERR_BITS   = COORD_BITS + 3;

    typedef logic [COORD_BITS-1:0]     t_coord;
    typedef logic signed [ERR_BITS-1:0] t_err;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_NEXT = 1'b1
    } t_cmd;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_coords;

    typedef struct packed {
        logic load;
        logic next;
    } t_ctrl;

    typedef struct packed {
        t_coord tile_x;
        t_coord tile_y;
        logic   valid_res;
        logic   last;
    } t_result;

    // one step toward smaller (neg) or larger coordinates, wrapping
    function automatic t_coord step_coord(input t_coord v, input logic neg);
        t_coord r;
        if (neg) begin
            r = v - COORD_BITS'(1);
        end else begin
            r = v + COORD_BITS'(1);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/flw_walker.sv =====
// line state registers and the per-item step logic
module flw_walker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  flw_pkg::t_ctrl   i_ctrl,
    input  flw_pkg::t_coords i_coords,
    output flw_pkg::t_result o_result
);

    localparam int C = flw_pkg::COORD_BITS;
    localparam int E = flw_pkg::ERR_BITS;

    flw_pkg::t_coord r_cur_x, r_cur_y, r_goal_x, r_goal_y, r_dx, r_dy;
    flw_pkg::t_coord n_cur_x, n_cur_y, n_goal_x, n_goal_y, n_dx, n_dy;
    logic            r_sx_neg, r_sy_neg, r_corner, r_active;
    logic            n_sx_neg, n_sy_neg, n_corner, n_active;
    flw_pkg::t_err   r_err, n_err;

    logic signed [E:0]   w_e2, w_dx_w, w_dy_w;
    flw_pkg::t_err       w_dx_e, w_dy_e;
    logic                w_move_x, w_move_y, w_at_goal;
    flw_pkg::t_coord     w_ld_dx, w_ld_dy;

    assign w_e2     = $signed({r_err, 1'b0});
    assign w_dx_w   = $signed({{(E + 1 - C){1'b0}}, r_dx});
    assign w_dy_w   = $signed({{(E + 1 - C){1'b0}}, r_dy});
    assign w_dx_e   = $signed({{(E - C){1'b0}}, r_dx});
    assign w_dy_e   = $signed({{(E - C){1'b0}}, r_dy});
    assign w_move_x = w_e2 > -w_dy_w;
    assign w_move_y = w_e2 < w_dx_w;
    assign w_at_goal = (r_cur_x == r_goal_x) && (r_cur_y == r_goal_y);

    assign w_ld_dx = (i_coords.start_x > i_coords.end_x) ?
                     (i_coords.start_x - i_coords.end_x) : (i_coords.end_x - i_coords.start_x);
    assign w_ld_dy = (i_coords.start_y > i_coords.end_y) ?
                     (i_coords.start_y - i_coords.end_y) : (i_coords.end_y - i_coords.start_y);

    always_comb begin
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_goal_x = r_goal_x;
        n_goal_y = r_goal_y;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_sx_neg = r_sx_neg;
        n_sy_neg = r_sy_neg;
        n_err    = r_err;
        n_corner = r_corner;
        n_active = r_active;
        o_result = '0;
        if (i_ctrl.load) begin
            n_cur_x  = i_coords.start_x;
            n_cur_y  = i_coords.start_y;
            n_goal_x = i_coords.end_x;
            n_goal_y = i_coords.end_y;
            n_dx     = w_ld_dx;
            n_dy     = w_ld_dy;
            n_sx_neg = !(i_coords.start_x < i_coords.end_x);
            n_sy_neg = !(i_coords.start_y < i_coords.end_y);
            n_err    = $signed({{(E - C){1'b0}}, w_ld_dx}) - $signed({{(E - C){1'b0}}, w_ld_dy});
            n_corner = 1'b0;
            n_active = 1'b1;
        end else if (i_ctrl.next && r_active) begin
            o_result.valid_res = 1'b1;
            o_result.tile_x    = r_cur_x;
            if (r_corner) begin
                // corner tile: x already moved, y one step back
                o_result.tile_y = flw_pkg::step_coord(r_cur_y, !r_sy_neg);
                n_corner        = 1'b0;
            end else begin
                o_result.tile_y = r_cur_y;
                if (w_at_goal) begin
                    o_result.last = 1'b1;
                    n_active      = 1'b0;
                end else begin
                    n_err = r_err - (w_move_x ? w_dy_e : '0) + (w_move_y ? w_dx_e : '0);
                    if (w_move_x) begin
                        n_cur_x = flw_pkg::step_coord(r_cur_x, r_sx_neg);
                    end
                    if (w_move_y) begin
                        n_cur_y = flw_pkg::step_coord(r_cur_y, r_sy_neg);
                    end
                    n_corner = w_move_x && w_move_y;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_goal_x <= '0;
            r_goal_y <= '0;
            r_dx     <= '0;
            r_dy     <= '0;
            r_sx_neg <= 1'b0;
            r_sy_neg <= 1'b0;
            r_err    <= '0;
            r_corner <= 1'b0;
            r_active <= 1'b0;
        end else begin
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_goal_x <= n_goal_x;
            r_goal_y <= n_goal_y;
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_sx_neg <= n_sx_neg;
            r_sy_neg <= n_sy_neg;
            r_err    <= n_err;
            r_corner <= n_corner;
            r_active <= n_active;
        end
    end

endmodule

// ===== rtl/core/flw_out_reg.sv =====
// result register between the step logic and the output channel
module flw_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic             i_take,
    input  flw_pkg::t_result i_result,
    output logic             o_valid,
    output flw_pkg::t_result o_result
);

    logic             r_valid, n_valid;
    flw_pkg::t_result r_result, n_result;

    always_comb begin
        n_valid  = r_valid;
        n_result = r_result;
        if (i_take) begin
            n_valid = 1'b0;
        end
        if (i_load) begin
            n_valid  = 1'b1;
            n_result = i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/core/four_connected_line_walker.sv =====
// Four-connected line walker. A load item (command 0) latches the start and end tiles and gives
// no result; each next item (command 1) gives one tile of the 4-connected Bresenham line, start
// tile first, end tile flagged by last, with the corner tile (new x, old y) given before the
// diagonal tile. A next item with no line active gives one result with valid_res = 0 and all
// other fields 0. One item is taken per cycle unless input is stalled; a result appears in the
// output register the cycle after its item is taken. The single result register sets the rate:
// while it is full and the output is stalled, input is stalled too; loads wait until it frees.
module four_connected_line_walker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_command,
    input  logic [flw_pkg::COORD_BITS-1:0]      i_start_x,
    input  logic [flw_pkg::COORD_BITS-1:0]      i_start_y,
    input  logic [flw_pkg::COORD_BITS-1:0]      i_end_x,
    input  logic [flw_pkg::COORD_BITS-1:0]      i_end_y,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [flw_pkg::COORD_BITS-1:0]      o_tile_x,
    output logic [flw_pkg::COORD_BITS-1:0]      o_tile_y,
    output logic                                o_valid_res,
    output logic                                o_last
);

    logic             w_accept;
    flw_pkg::t_ctrl   w_ctrl;
    flw_pkg::t_coords w_coords;
    flw_pkg::t_result w_step_res, w_out_res;

    assign o_stall  = o_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    assign w_ctrl.load = w_accept && (i_command == flw_pkg::CMD_LOAD);
    assign w_ctrl.next = w_accept && (i_command == flw_pkg::CMD_NEXT);

    assign w_coords.start_x = i_start_x;
    assign w_coords.start_y = i_start_y;
    assign w_coords.end_x   = i_end_x;
    assign w_coords.end_y   = i_end_y;

    flw_walker u_walker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_coords (w_coords),
        .o_result (w_step_res)
    );

    flw_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_ctrl.next),
        .i_take   (o_valid && !i_stall),
        .i_result (w_step_res),
        .o_valid  (o_valid),
        .o_result (w_out_res)
    );

    assign o_tile_x    = w_out_res.tile_x;
    assign o_tile_y    = w_out_res.tile_y;
    assign o_valid_res = w_out_res.valid_res;
    assign o_last      = w_out_res.last;

endmodule

// ===== rtl/core/flw_checker.sv =====
// port-level checks for the line walker, bound to the top level
`include "assert_macros.svh"

module flw_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_stall,
    input logic                           i_command,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic [flw_pkg::COORD_BITS-1:0] o_tile_x,
    input logic [flw_pkg::COORD_BITS-1:0] o_tile_y,
    input logic                           o_valid_res,
    input logic                           o_last
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_tile_x) && $stable(o_tile_y) && $stable(o_valid_res) && $stable(o_last), "stalled result changed")

    `ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input stalled without a blocked result")

    `ASSERT_SAME(a_empty_zero, i_clk, i_rst_n, o_valid && !o_valid_res, o_tile_x == '0 && o_tile_y == '0 && !o_last, "empty result carries data")

    `ASSERT_NEXT(a_next_gives, i_clk, i_rst_n, i_valid && !o_stall && i_command == flw_pkg::CMD_NEXT, o_valid, "next item gave no result")

endmodule

bind four_connected_line_walker flw_checker u_flw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_command   (i_command),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_tile_x    (o_tile_x),
    .o_tile_y    (o_tile_y),
    .o_valid_res (o_valid_res),
    .o_last      (o_last)
);
